// File: hdl/tgbd_pkg.sv
// shared types and constants for the tile grid boundary detector
// no dependencies; used by tgbd_line_buf, the top level and its checker
package tgbd_pkg;

  localparam int unsigned MaxWidth   = 128;
  localparam int unsigned MaxHeight  = 64;

  localparam int unsigned ColW       = $clog2(MaxWidth);
  localparam int unsigned RowW       = $clog2(MaxHeight);
  localparam int unsigned RowCntW    = $clog2(MaxHeight + 1);

  localparam int unsigned TileIdW    = 32;
  localparam int unsigned WidthRegW  = 8;
  localparam int unsigned HeightRegW = 7;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 8;

  typedef enum logic [CfgIdxW-1:0] {
    RegGridWidth  = 2'd0,
    RegGridHeight = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic [TileIdW-1:0] tile_id;
    logic               flush;
  } tile_req_t;

  typedef struct packed {
    logic [ColW-1:0] column;
    logic [RowW-1:0] row;
    logic            is_border;
    logic            last;
  } tile_res_t;

  // occupancy of one column: two rows up and one row up
  typedef struct packed {
    logic upper;
    logic pending;
  } occ_entry_t;

endpackage

// File: hdl/tile_grid_boundary_detect_unit.sv
// top level of the tile grid boundary detector
// depends on tgbd_pkg and tgbd_line_buf
//
// Tiles enter in raster order, one request per clock, and a tile with a
// nonzero id is occupied. The decision for row r leaves while row r+1
// streams in, so row 0 gives no result and every later request gives one;
// after the last row the host sends grid_width flush requests to release
// the bottom row, and its final result carries last. For each request
// the block reads two columns of a 128-entry occupancy line
// buffer and writes one back per cycle, and the read for the next column
// is already under way when a request is taken. in_ready_o falls only
// while a result waits in the output register and out_ready_i is low.
// Writing grid_width or grid_height restarts the stream at row 0.
module tile_grid_boundary_detect_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  tgbd_pkg::tile_req_t           in_req_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output tgbd_pkg::tile_res_t           out_res_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tgbd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [tgbd_pkg::CfgDataW-1:0] cfg_data_i
);
  import tgbd_pkg::*;

  logic [ColW-1:0]    col_q, col_d;
  logic [RowCntW-1:0] row_q, row_d;
  logic [ColW-1:0]    wlast_q, wlast_d;
  logic [RowCntW-1:0] height_q, height_d;
  logic               left_q;
  logic               out_valid_q;
  tile_res_t          out_res_q;

  logic       in_acc;
  logic       first_row;
  logic       row_end;
  logic       occ;
  logic       left_occ;
  logic       right_occ;
  logic       border;
  occ_entry_t rd_a;
  occ_entry_t rd_b;
  occ_entry_t wdata;
  logic [ColW-1:0] raddr_b;

  // out-of-range widths and heights clamp to the legal span
  function automatic logic [ColW-1:0] width_last(logic [WidthRegW-1:0] v);
    logic [ColW-1:0] res;
    if (v == '0) begin
      res = '0;
    end else if (32'(v) > MaxWidth) begin
      res = ColW'(MaxWidth - 1);
    end else begin
      res = ColW'(v - WidthRegW'(1));
    end
    return res;
  endfunction

  function automatic logic [RowCntW-1:0] height_eff(logic [HeightRegW-1:0] v);
    logic [RowCntW-1:0] res;
    if (v == '0) begin
      res = RowCntW'(1);
    end else if (32'(v) > MaxHeight) begin
      res = RowCntW'(MaxHeight);
    end else begin
      res = RowCntW'(v);
    end
    return res;
  endfunction

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_acc      = in_valid_i && in_ready_o;

  assign first_row = (row_q == '0);
  assign row_end   = (col_q == wlast_q);

  // the row below the grid is always empty
  assign occ = (in_req_i.tile_id != '0) && !in_req_i.flush && (row_q < height_q);

  assign left_occ  = (col_q != '0) && left_q;
  assign right_occ = !row_end && rd_b.pending;
  assign border    = rd_a.pending && (!rd_a.upper || !occ || !left_occ || !right_occ);

  always_comb begin
    wdata.pending = occ;
    wdata.upper   = first_row ? 1'b0 : rd_a.pending;
  end

  always_comb begin
    col_d    = col_q;
    row_d    = row_q;
    wlast_d  = wlast_q;
    height_d = height_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegGridWidth: begin
          wlast_d = width_last(cfg_data_i[WidthRegW-1:0]);
          col_d   = '0;
          row_d   = '0;
        end
        RegGridHeight: begin
          height_d = height_eff(cfg_data_i[HeightRegW-1:0]);
          col_d    = '0;
          row_d    = '0;
        end
        default: ;
      endcase
    end else if (in_acc) begin
      if (row_end) begin
        col_d = '0;
        row_d = (row_q == height_q) ? '0 : row_q + RowCntW'(1);
      end else begin
        col_d = col_q + ColW'(1);
      end
    end
  end

  // read ahead for the column that comes next
  assign raddr_b = col_d + ColW'(1);

  tgbd_line_buf u_line_buf (
    .clk_i     (clk_i),
    .we_i      (in_acc),
    .waddr_i   (col_q),
    .wdata_i   (wdata),
    .raddr_a_i (col_d),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      wlast_q     <= ColW'(MaxWidth - 1);
      height_q    <= RowCntW'(MaxHeight);
      out_valid_q <= 1'b0;
    end else begin
      col_q    <= col_d;
      row_q    <= row_d;
      wlast_q  <= wlast_d;
      height_q <= height_d;
      if (in_acc) begin
        out_valid_q <= !first_row;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // left neighbour is the previous column of the row being decided
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      left_q <= rd_a.pending;
    end
    if (in_acc && !first_row) begin
      out_res_q.column    <= col_q;
      out_res_q.row       <= RowW'(row_q - RowCntW'(1));
      out_res_q.is_border <= border;
      out_res_q.last      <= (row_q == height_q) && row_end;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

endmodule

// File: hdl/tgbd_line_buf.sv
// two-row occupancy line buffer: one write port, two registered read ports
// depends on tgbd_pkg; a write to an address being read is forwarded
module tgbd_line_buf (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [tgbd_pkg::ColW-1:0] waddr_i,
  input  tgbd_pkg::occ_entry_t  wdata_i,
  input  logic [tgbd_pkg::ColW-1:0] raddr_a_i,
  input  logic [tgbd_pkg::ColW-1:0] raddr_b_i,
  output tgbd_pkg::occ_entry_t  rdata_a_o,
  output tgbd_pkg::occ_entry_t  rdata_b_o
);
  import tgbd_pkg::*;

  occ_entry_t mem_q [MaxWidth];
  occ_entry_t rdata_a_q;
  occ_entry_t rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_a_q <= (we_i && (waddr_i == raddr_a_i)) ? wdata_i : mem_q[raddr_a_i];
    rdata_b_q <= (we_i && (waddr_i == raddr_b_i)) ? wdata_i : mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// File: hdl/tgbd_checker.sv
// port-level checks for tile_grid_boundary_detect_unit
// depends on tgbd_pkg; bound to the top level below
module tgbd_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input tgbd_pkg::tile_res_t out_res_o
);
  import tgbd_pkg::*;

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_res_o))
    else $error("stalled result changed or dropped");

  // an empty output register never blocks a request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output register");

  // a result only appears after a request was taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o))
    else $error("result without a request");

  // a taken result with no new request leaves the register empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !(in_valid_i && in_ready_o) |=> !out_valid_o)
    else $error("result repeated");

endmodule

bind tile_grid_boundary_detect_unit tgbd_checker u_tgbd_checker (.*);
